### hw/rtl/pts_pkg.sv
`timescale 1ns / 1ps

package pts_pkg;

   typedef enum logic [2:0] {
      TK_IDENT   = 3'd0,
      TK_INCLUDE = 3'd1,
      TK_DEFINE  = 3'd2,
      TK_STRING  = 3'd3,
      TK_POUND   = 3'd4,
      TK_LANGLE  = 3'd5,
      TK_RANGLE  = 3'd6,
      TK_END     = 3'd7
   } token_kind_type;

   typedef enum logic [11:0] {
      SM_IDLE     = 12'b0000_0000_0001,
      SM_IDENT    = 12'b0000_0000_0010,
      SM_STR      = 12'b0000_0000_0100,
      SM_STR_ESC  = 12'b0000_0000_1000,
      SM_DEC      = 12'b0000_0001_0000,
      SM_ZERO     = 12'b0000_0010_0000,
      SM_HEX      = 12'b0000_0100_0000,
      SM_BIN      = 12'b0000_1000_0000,
      SM_OCT      = 12'b0001_0000_0000,
      SM_CH_OPEN  = 12'b0010_0000_0000,
      SM_CH_ESC   = 12'b0100_0000_0000,
      SM_CH_CLOSE = 12'b1000_0000_0000
   } scan_mode_type;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_POUND  = 8'h23;
   localparam logic [7:0] CH_APOS   = 8'h27;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_GT     = 8'h3E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_X      = 8'h78;

   localparam int INCLUDE_LEN = 7;
   localparam int DEFINE_LEN  = 6;

   typedef struct packed {
      scan_mode_type  mode;
      logic           tok_valid;
      token_kind_type tok_kind;
      logic           start_ident;
      logic           start_str;
   } dispatch_type;

   typedef struct packed {
      logic           clear;
      logic           append;
      logic [7:0]     append_char;
      logic           load_token;
      token_kind_type token_kind;
      logic           load_run;
      token_kind_type run_kind;
      logic           run_start;
      logic           run_next;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_include;
      logic is_define;
      logic run_last;
   } dp_status_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic is_oct(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h37;
   endfunction

   function automatic logic [7:0] include_char(input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0: r = 8'h69;
         3'd1: r = 8'h6E;
         3'd2: r = 8'h63;
         3'd3: r = 8'h6C;
         3'd4: r = 8'h75;
         3'd5: r = 8'h64;
         3'd6: r = 8'h65;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] define_char(input logic [2:0] i);
      logic [7:0] r;
      unique case (i)
         3'd0: r = 8'h64;
         3'd1: r = 8'h65;
         3'd2: r = 8'h66;
         3'd3: r = 8'h69;
         3'd4: r = 8'h6E;
         3'd5: r = 8'h65;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   // idle-mode handling of one character
   function automatic dispatch_type dispatch(input logic [7:0] c);
      dispatch_type d;
      d = '{mode: SM_IDLE, tok_valid: 1'b0, tok_kind: TK_IDENT,
            start_ident: 1'b0, start_str: 1'b0};
      if (is_alpha(c)) begin
         d.mode        = SM_IDENT;
         d.start_ident = 1'b1;
      end else if (is_digit(c)) begin
         d.mode = (c == CH_ZERO) ? SM_ZERO : SM_DEC;
      end else if (c == CH_DQUOTE) begin
         d.mode      = SM_STR;
         d.start_str = 1'b1;
      end else if (c == CH_APOS) begin
         d.mode = SM_CH_OPEN;
      end else if (c == CH_POUND) begin
         d.tok_valid = 1'b1;
         d.tok_kind  = TK_POUND;
      end else if (c == CH_LT) begin
         d.tok_valid = 1'b1;
         d.tok_kind  = TK_LANGLE;
      end else if (c == CH_GT) begin
         d.tok_valid = 1'b1;
         d.tok_kind  = TK_RANGLE;
      end
      return d;
   endfunction

endpackage

### hw/rtl/preprocessor_token_scanner.sv
`timescale 1ns / 1ps

// Lexical scanner for a small preprocessor subset. One source character enters per
// item on req (tuser marks end of input); tokens leave on rsp, one item per
// identifier or string character, or one item per keyword, '#', '<', '>' or END.
// A character that produces no result, or one single-item token, needs no extra step.
// Identifier and string runs are read back from the text buffer through its registered
// read port, with a read step and an output step per emitted character; input is held
// off meanwhile. A token after a run or a keyword takes an extra token step. Text beyond
// MAX_TEXT_LEN characters is dropped and the run is marked truncated.
module preprocessor_token_scanner
   import pts_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tuser,   // [0] end_of_input
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_value
   output logic       rsp_tlast,
   output logic [4:0] rsp_tuser    // [2:0] token_kind, [3] char_valid, [4] truncated
);

   dp_cmd_type    cmd;
   dp_status_type status;

   pts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   pts_data #(
      .MAX_TEXT_LEN (MAX_TEXT_LEN)
   ) u_data (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### hw/rtl/pts_ctrl.sv
`timescale 1ns / 1ps

module pts_ctrl
   import pts_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,
   input  logic          req_tuser,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_SCAN   = 4'b0001,
      ST_RUN_RD = 4'b0010,
      ST_RUN_OUT = 4'b0100,
      ST_TOKEN  = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   scan_mode_type  mode_ff, mode_in;
   logic           pend_valid_ff, pend_valid_in;
   token_kind_type pend_kind_ff, pend_kind_in;
   token_kind_type run_kind_ff, run_kind_in;

   dispatch_type   disp;
   logic           accept;
   logic           do_disp, flush, close_str, clr, app, tok_valid, keyword, run_needed;
   logic [7:0]     app_char;
   token_kind_type tok_kind;
   logic [7:0]     c;

   assign c          = req_tdata;
   assign disp       = dispatch(c);
   assign req_tready = (state_ff == ST_SCAN) && status.out_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      do_disp   = 1'b0;
      flush     = 1'b0;
      close_str = 1'b0;
      clr       = 1'b0;
      app       = 1'b0;
      app_char  = c;
      tok_valid = 1'b0;
      tok_kind  = TK_END;
      mode_in   = mode_ff;
      if (accept) begin
         if (req_tuser) begin
            flush     = (mode_ff == SM_IDENT);
            tok_valid = 1'b1;
            tok_kind  = TK_END;
            clr       = 1'b1;
            mode_in   = SM_IDLE;
         end else begin
            unique case (mode_ff)
               SM_IDENT: begin
                  if (is_alpha(c) || is_digit(c)) begin
                     app = 1'b1;
                  end else begin
                     flush   = 1'b1;
                     do_disp = 1'b1;
                  end
               end
               SM_STR: begin
                  priority if (c == CH_DQUOTE) begin
                     close_str = 1'b1;
                     mode_in   = SM_IDLE;
                  end else if (c == CH_BSLASH) begin
                     mode_in = SM_STR_ESC;
                  end else if (c == CH_NL) begin
                     clr     = 1'b1;
                     mode_in = SM_IDLE;
                  end else begin
                     app = 1'b1;
                  end
               end
               SM_STR_ESC: begin
                  mode_in = SM_STR;
                  app     = (c != CH_NL);
                  priority if (c == CH_N) begin
                     app_char = CH_NL;
                  end else if (c == CH_T) begin
                     app_char = CH_TAB;
                  end else if (c == CH_ZERO) begin
                     app_char = 8'h00;
                  end else begin
                     app_char = c;
                  end
               end
               SM_DEC: do_disp = !is_digit(c);
               SM_ZERO: begin
                  priority if (c == CH_X) begin
                     mode_in = SM_HEX;
                  end else if (c == CH_B) begin
                     mode_in = SM_BIN;
                  end else if (is_oct(c)) begin
                     mode_in = SM_OCT;
                  end else begin
                     do_disp = 1'b1;
                  end
               end
               SM_HEX: do_disp = !is_hex(c);
               SM_BIN: do_disp = !(c == CH_ZERO || c == 8'h31);
               SM_OCT: do_disp = !is_oct(c);
               SM_CH_OPEN: mode_in = (c == CH_BSLASH) ? SM_CH_ESC : SM_CH_CLOSE;
               SM_CH_ESC: mode_in = SM_CH_CLOSE;
               SM_CH_CLOSE: begin
                  if (c == CH_APOS) begin
                     mode_in = SM_IDLE;
                  end else begin
                     do_disp = 1'b1;
                  end
               end
               SM_IDLE: do_disp = 1'b1;
               default: do_disp = 1'b1;
            endcase
            if (do_disp) begin
               mode_in   = disp.mode;
               tok_valid = disp.tok_valid;
               tok_kind  = disp.tok_kind;
               if (disp.start_ident) begin
                  clr = 1'b1;
                  app = 1'b1;
               end
               if (disp.start_str) begin
                  clr = 1'b1;
               end
            end
         end
      end
   end

   assign keyword    = flush && (status.is_include || status.is_define);
   assign run_needed = close_str || (flush && !keyword);

   always_comb begin
      cmd           = '0;
      cmd.token_kind = TK_END;
      cmd.run_kind  = run_kind_ff;
      state_in      = state_ff;
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      run_kind_in   = run_kind_ff;
      unique case (state_ff)
         ST_SCAN: begin
            if (accept) begin
               cmd.clear       = (clr || keyword) && !run_needed;
               cmd.append      = app;
               cmd.append_char = app_char;
               if (keyword) begin
                  cmd.load_token = 1'b1;
                  cmd.token_kind = status.is_include ? TK_INCLUDE : TK_DEFINE;
                  pend_valid_in  = tok_valid;
                  pend_kind_in   = tok_kind;
                  state_in       = tok_valid ? ST_TOKEN : ST_SCAN;
               end else if (run_needed) begin
                  cmd.run_start = 1'b1;
                  run_kind_in   = close_str ? TK_STRING : TK_IDENT;
                  pend_valid_in = tok_valid;
                  pend_kind_in  = tok_kind;
                  state_in      = ST_RUN_RD;
               end else if (tok_valid) begin
                  cmd.load_token = 1'b1;
                  cmd.token_kind = tok_kind;
               end
            end
         end
         ST_RUN_RD: state_in = ST_RUN_OUT;
         ST_RUN_OUT: begin
            if (status.out_free) begin
               cmd.load_run = 1'b1;
               if (status.run_last) begin
                  cmd.clear = 1'b1;
                  state_in  = pend_valid_ff ? ST_TOKEN : ST_SCAN;
               end else begin
                  cmd.run_next = 1'b1;
                  state_in     = ST_RUN_RD;
               end
            end
         end
         ST_TOKEN: begin
            if (status.out_free) begin
               cmd.load_token = 1'b1;
               cmd.token_kind = pend_kind_ff;
               pend_valid_in  = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         default: state_in = ST_SCAN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SCAN;
         mode_ff       <= SM_IDLE;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_kind_ff <= pend_kind_in;
      run_kind_ff  <= run_kind_in;
   end

   a_rd_then_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN_RD |=> state_ff == ST_RUN_OUT)
      else $error("run read not followed by output step");

   a_token_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TOKEN |-> pend_valid_ff)
      else $error("token step without a pending token");

   a_mode_still: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |=> $stable(mode_ff))
      else $error("scan mode changed while emitting");

endmodule

### hw/rtl/pts_data.sv
`timescale 1ns / 1ps

module pts_data
   import pts_pkg::*;
#(
   parameter int MAX_TEXT_LEN = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,
   output logic          rsp_tlast,
   output logic [4:0]    rsp_tuser
);

   localparam int LEN_W = $clog2(MAX_TEXT_LEN + 1);
   localparam int IDX_W = $clog2(MAX_TEXT_LEN);

   logic [7:0]       text_buf_ff [MAX_TEXT_LEN];
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic             inc_ok_ff, inc_ok_in;
   logic             def_ok_ff, def_ok_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       rd_data_ff;

   logic             out_valid_ff, out_valid_in;
   token_kind_type   out_kind_ff, out_kind_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_cvalid_ff, out_cvalid_in;
   logic             out_last_ff, out_last_in;
   logic             out_trunc_ff, out_trunc_in;

   logic [LEN_W-1:0] pos;
   logic             room, wr_en, out_free, run_last;

   assign pos      = cmd.clear ? '0 : len_ff;
   assign room     = pos < LEN_W'(MAX_TEXT_LEN);
   assign wr_en    = cmd.append && room;
   assign out_free = !out_valid_ff || rsp_tready;
   assign run_last = (len_ff == '0) || (LEN_W'(idx_ff) + LEN_W'(1) == len_ff);

   assign status.out_free   = out_free;
   assign status.is_include = !ovf_ff && len_ff == LEN_W'(INCLUDE_LEN) && inc_ok_ff;
   assign status.is_define  = !ovf_ff && len_ff == LEN_W'(DEFINE_LEN) && def_ok_ff;
   assign status.run_last   = run_last;

   always_comb begin
      len_in    = cmd.clear ? '0 : len_ff;
      ovf_in    = cmd.clear ? 1'b0 : ovf_ff;
      inc_ok_in = cmd.clear ? 1'b1 : inc_ok_ff;
      def_ok_in = cmd.clear ? 1'b1 : def_ok_ff;
      if (cmd.append) begin
         if (room) begin
            len_in = pos + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         inc_ok_in = inc_ok_in && pos < LEN_W'(INCLUDE_LEN)
                     && cmd.append_char == include_char(pos[2:0]);
         def_ok_in = def_ok_in && pos < LEN_W'(DEFINE_LEN)
                     && cmd.append_char == define_char(pos[2:0]);
      end
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.run_start) begin
         idx_in = '0;
      end else if (cmd.run_next) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_kind_in   = out_kind_ff;
      out_char_in   = out_char_ff;
      out_cvalid_in = out_cvalid_ff;
      out_last_in   = out_last_ff;
      out_trunc_in  = out_trunc_ff;
      priority if (cmd.load_token) begin
         out_valid_in  = 1'b1;
         out_kind_in   = cmd.token_kind;
         out_char_in   = 8'h00;
         out_cvalid_in = 1'b0;
         out_last_in   = 1'b1;
         out_trunc_in  = 1'b0;
      end else if (cmd.load_run) begin
         out_valid_in  = 1'b1;
         out_kind_in   = cmd.run_kind;
         out_char_in   = (len_ff == '0) ? 8'h00 : rd_data_ff;
         out_cvalid_in = (len_ff != '0);
         out_last_in   = run_last;
         out_trunc_in  = ovf_ff;
      end else begin
         out_kind_in = out_kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         text_buf_ff[pos[IDX_W-1:0]] <= cmd.append_char;
      end
      rd_data_ff <= text_buf_ff[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         inc_ok_ff    <= 1'b1;
         def_ok_ff    <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         inc_ok_ff    <= inc_ok_in;
         def_ok_ff    <= def_ok_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      out_kind_ff   <= out_kind_in;
      out_char_ff   <= out_char_in;
      out_cvalid_ff <= out_cvalid_in;
      out_last_ff   <= out_last_in;
      out_trunc_ff  <= out_trunc_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_char_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_trunc_ff, out_cvalid_ff, out_kind_ff};

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(MAX_TEXT_LEN))
      else $error("text length beyond buffer");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> len_ff == LEN_W'(MAX_TEXT_LEN))
      else $error("overflow flagged with buffer not full");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_token || cmd.load_run) |-> out_free)
      else $error("result loaded over a waiting item");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load_token && cmd.load_run))
      else $error("token and run item loaded together");

endmodule
